### src/assert_macros.svh
// Assertion macros shared by the projection RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a clocked property, skipped while reset is high
`define ASSERT_CLK(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
// Check that a condition never holds at a clock edge
`define ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

### src/cvp_pkg.sv
// Types, widths and register codes of the camera vertex projection.
package cvp_pkg;

   localparam int SCREEN_WIDTH_DEF  = 1024;
   localparam int SCREEN_HEIGHT_DEF = 768;

   localparam int COORD_W   = 32;                 // Q16.16 coordinate
   localparam int COORD_FRAC = 16;
   localparam int AXIS_W    = 48;                 // three packed axis components
   localparam int COMP_W    = 16;                 // Q2.14 component
   localparam int COMP_FRAC = 14;
   localparam int PROD_W    = 2 * COORD_W;        // w * camera position
   localparam int DIFF_W    = PROD_W - COORD_FRAC + 1;
   localparam int MUL_W     = DIFF_W + COMP_W;    // difference * component
   localparam int PART_W    = MUL_W - COMP_FRAC;  // floored partial product
   localparam int DOT_W     = PART_W + 2;         // sum of three partials
   localparam int K_W       = 14;                 // 3 * half screen, up to 12288
   localparam int NUM_W     = DOT_W + K_W - 1;    // scaled numerator magnitude
   localparam int DEN_W     = DOT_W + 1;          // twice the depth magnitude
   localparam int QUO_W     = 18;                 // quotient bits before clamping
   localparam int REM_W     = DEN_W + QUO_W;
   localparam int OFS_W     = QUO_W + 2;          // signed screen offset
   localparam int SCR_W     = 16;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CAM_POS_X    = 3'd0,
      CSR_CAM_POS_Y    = 3'd1,
      CSR_CAM_POS_Z    = 3'd2,
      CSR_RIGHT_AXIS   = 3'd3,
      CSR_UP_AXIS      = 3'd4,
      CSR_FORWARD_AXIS = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [COORD_W-1:0] vertex_z;
      logic signed [COORD_W-1:0] vertex_w;
      logic                      last_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [SCR_W-1:0] screen_x;
      logic signed [SCR_W-1:0] screen_y;
      logic                    visible;
      logic                    last_out;
   } rsp_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cam_pos_x;
      logic signed [COORD_W-1:0] cam_pos_y;
      logic signed [COORD_W-1:0] cam_pos_z;
      logic [AXIS_W-1:0]         right_axis;
      logic [AXIS_W-1:0]         up_axis;
      logic [AXIS_W-1:0]         forward_axis;
   } csr_regs_type;

   typedef struct packed {
      logic signed [DOT_W-1:0]   vx;
      logic signed [DOT_W-1:0]   vy;
      logic signed [DOT_W-1:0]   vz;
      logic signed [COORD_W-1:0] w;
      logic                      last;
   } view_type;

   typedef struct packed {
      logic ovf_x;
      logic ovf_y;
      logic zero_x;
      logic zero_y;
      logic neg_x;
      logic neg_y;
      logic depth_ok;
      logic last;
   } flags_type;

   typedef struct packed {
      logic [NUM_W-1:0] num_x;
      logic [NUM_W-1:0] num_y;
      logic [DEN_W-1:0] den;
      flags_type        flags;
   } div_op_type;

   typedef struct packed {
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      flags_type        flags;
   } div_res_type;

endpackage

### src/cvp_xform.sv
// World to view transform: camera offset, then dot products with the axes.
module cvp_xform (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  cvp_pkg::csr_regs_type    regs,
   input  logic                     in_valid,
   input  cvp_pkg::req_payload_type in_data,
   output logic                     out_valid,
   output cvp_pkg::view_type        out_data
);

   logic [3:0] valid_ff;

   // stage 1: w times camera position
   logic signed [cvp_pkg::PROD_W-1:0]  wp_in [3];
   logic signed [cvp_pkg::PROD_W-1:0]  wp_ff [3];
   cvp_pkg::req_payload_type           s1_ff;
   // stage 2: vertex minus scaled camera position
   logic signed [cvp_pkg::DIFF_W-1:0]  d_in [3];
   logic signed [cvp_pkg::DIFF_W-1:0]  d_ff [3];
   logic signed [cvp_pkg::COORD_W-1:0] s2_w_ff;
   logic                               s2_last_ff;
   // stage 3: floored axis products
   logic signed [cvp_pkg::MUL_W-1:0]   m_full [3][3];
   logic signed [cvp_pkg::PART_W-1:0]  m_in [3][3];
   logic signed [cvp_pkg::PART_W-1:0]  m_ff [3][3];
   logic signed [cvp_pkg::COORD_W-1:0] s3_w_ff;
   logic                               s3_last_ff;
   // stage 4: dot product sums
   cvp_pkg::view_type                  out_in;
   cvp_pkg::view_type                  out_ff;

   logic signed [cvp_pkg::COORD_W-1:0] cam [3];
   logic signed [cvp_pkg::COORD_W-1:0] vin [3];
   logic [cvp_pkg::AXIS_W-1:0]         axis [3];

   assign cam[0]  = regs.cam_pos_x;
   assign cam[1]  = regs.cam_pos_y;
   assign cam[2]  = regs.cam_pos_z;
   assign vin[0]  = s1_ff.vertex_x;
   assign vin[1]  = s1_ff.vertex_y;
   assign vin[2]  = s1_ff.vertex_z;
   assign axis[0] = regs.right_axis;
   assign axis[1] = regs.up_axis;
   assign axis[2] = regs.forward_axis;

   // form the per-stage results
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         wp_in[i] = cvp_pkg::PROD_W'(in_data.vertex_w) * cvp_pkg::PROD_W'(cam[i]);
         d_in[i]  = cvp_pkg::DIFF_W'(vin[i])
                  - cvp_pkg::DIFF_W'($signed(wp_ff[i][cvp_pkg::PROD_W-1:cvp_pkg::COORD_FRAC]));
      end
      for (int a = 0; a < 3; a++) begin
         for (int c = 0; c < 3; c++) begin
            m_full[a][c] = cvp_pkg::MUL_W'(d_ff[c])
               * cvp_pkg::MUL_W'($signed(axis[a][c*cvp_pkg::COMP_W +: cvp_pkg::COMP_W]));
            m_in[a][c] = m_full[a][c][cvp_pkg::MUL_W-1:cvp_pkg::COMP_FRAC];
         end
      end
      out_in.vx   = cvp_pkg::DOT_W'(m_ff[0][0]) + cvp_pkg::DOT_W'(m_ff[0][1])
                  + cvp_pkg::DOT_W'(m_ff[0][2]);
      out_in.vy   = cvp_pkg::DOT_W'(m_ff[1][0]) + cvp_pkg::DOT_W'(m_ff[1][1])
                  + cvp_pkg::DOT_W'(m_ff[1][2]);
      out_in.vz   = cvp_pkg::DOT_W'(m_ff[2][0]) + cvp_pkg::DOT_W'(m_ff[2][1])
                  + cvp_pkg::DOT_W'(m_ff[2][2]);
      out_in.w    = s3_w_ff;
      out_in.last = s3_last_ff;
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (advance) begin
         wp_ff      <= wp_in;
         s1_ff      <= in_data;
         d_ff       <= d_in;
         s2_w_ff    <= s1_ff.vertex_w;
         s2_last_ff <= s1_ff.last_in;
         m_ff       <= m_in;
         s3_w_ff    <= s2_w_ff;
         s3_last_ff <= s2_last_ff;
         out_ff     <= out_in;
      end
   end

   assign out_valid = valid_ff[3];
   assign out_data  = out_ff;

endmodule

### src/cvp_prep.sv
// Divider operand preparation: magnitudes, signs, depth test, scaling, overflow.
module cvp_prep #(
   parameter int SCREEN_WIDTH  = cvp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = cvp_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  cvp_pkg::view_type    in_data,
   output logic                 out_valid,
   output cvp_pkg::div_op_type  out_data
);

   localparam logic [cvp_pkg::K_W-1:0] K_X = cvp_pkg::K_W'(3 * (SCREEN_WIDTH / 2));
   localparam logic [cvp_pkg::K_W-1:0] K_Y = cvp_pkg::K_W'(3 * (SCREEN_HEIGHT / 2));

   logic [2:0] valid_ff;

   // stage A: magnitudes and flags
   logic [cvp_pkg::DOT_W-1:0]       ax_in, ay_in, ad_in;
   logic [cvp_pkg::DOT_W-1:0]       ax_ff, ay_ff, ad_ff;
   cvp_pkg::flags_type              fa_in, fa_ff;
   logic signed [cvp_pkg::DOT_W-1:0] w_ext;
   // stage B: scaled numerators and denominator
   logic [cvp_pkg::NUM_W-1:0]       nx_in, ny_in, nx_ff, ny_ff;
   logic [cvp_pkg::DEN_W-1:0]       den_in, den_ff;
   cvp_pkg::flags_type              fb_ff;
   // stage C: quotient range check
   cvp_pkg::div_op_type             out_in, out_ff;

   always_comb begin
      ax_in = in_data.vx[cvp_pkg::DOT_W-1] ? cvp_pkg::DOT_W'(-in_data.vx)
                                            : cvp_pkg::DOT_W'(in_data.vx);
      ay_in = in_data.vy[cvp_pkg::DOT_W-1] ? cvp_pkg::DOT_W'(-in_data.vy)
                                            : cvp_pkg::DOT_W'(in_data.vy);
      ad_in = in_data.vz[cvp_pkg::DOT_W-1] ? cvp_pkg::DOT_W'(-in_data.vz)
                                            : cvp_pkg::DOT_W'(in_data.vz);
      w_ext = cvp_pkg::DOT_W'(in_data.w);

      fa_in        = '0;
      fa_in.zero_x = (in_data.vx == '0);
      fa_in.zero_y = (in_data.vy == '0);
      // x divides by depth, y by negated depth
      fa_in.neg_x  = (in_data.vx < 0) != (in_data.vz < 0);
      fa_in.neg_y  = (in_data.vy < 0) != (in_data.vz > 0);
      fa_in.last   = in_data.last;
      // depth over weight above one, zero weight counts as infinite depth
      priority if (in_data.w > 0) begin
         fa_in.depth_ok = in_data.vz > w_ext;
      end else if (in_data.w < 0) begin
         fa_in.depth_ok = in_data.vz < w_ext;
      end else begin
         fa_in.depth_ok = in_data.vz > 0;
      end

      nx_in  = cvp_pkg::NUM_W'(ax_ff) * cvp_pkg::NUM_W'(K_X);
      ny_in  = cvp_pkg::NUM_W'(ay_ff) * cvp_pkg::NUM_W'(K_Y);
      den_in = {ad_ff, 1'b0};

      // flag quotients that do not fit, a zero denominator included
      out_in.num_x       = nx_ff;
      out_in.num_y       = ny_ff;
      out_in.den         = den_ff;
      out_in.flags       = fb_ff;
      out_in.flags.ovf_x = {{(cvp_pkg::REM_W-cvp_pkg::NUM_W){1'b0}}, nx_ff}
                           >= {den_ff, {cvp_pkg::QUO_W{1'b0}}};
      out_in.flags.ovf_y = {{(cvp_pkg::REM_W-cvp_pkg::NUM_W){1'b0}}, ny_ff}
                           >= {den_ff, {cvp_pkg::QUO_W{1'b0}}};
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (advance) begin
         ax_ff  <= ax_in;
         ay_ff  <= ay_in;
         ad_ff  <= ad_in;
         fa_ff  <= fa_in;
         nx_ff  <= nx_in;
         ny_ff  <= ny_in;
         den_ff <= den_in;
         fb_ff  <= fa_ff;
         out_ff <= out_in;
      end
   end

   assign out_valid = valid_ff[2];
   assign out_data  = out_ff;

endmodule

### src/cvp_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes on one divisor.
module cvp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  cvp_pkg::div_op_type  in_data,
   output logic                 out_valid,
   output cvp_pkg::div_res_type out_data
);

   localparam int N = cvp_pkg::QUO_W;

   logic [N-1:0]                valid_ff;
   logic [cvp_pkg::REM_W-1:0]   rx_src [N], ry_src [N], rx_in [N], ry_in [N];
   logic [cvp_pkg::REM_W-1:0]   rx_ff [N], ry_ff [N];
   logic [N-1:0]                qx_src [N], qy_src [N], qx_in [N], qy_in [N];
   logic [N-1:0]                qx_ff [N], qy_ff [N];
   logic [cvp_pkg::DEN_W-1:0]   den_src [N], den_ff [N];
   cvp_pkg::flags_type          fl_src [N], fl_ff [N];
   logic [cvp_pkg::REM_W-1:0]   trial [N];

   // route each stage's source, first stage from the input
   always_comb begin
      rx_src[0]  = cvp_pkg::REM_W'(in_data.num_x);
      ry_src[0]  = cvp_pkg::REM_W'(in_data.num_y);
      qx_src[0]  = '0;
      qy_src[0]  = '0;
      den_src[0] = in_data.den;
      fl_src[0]  = in_data.flags;
      for (int s = 1; s < N; s++) begin
         rx_src[s]  = rx_ff[s-1];
         ry_src[s]  = ry_ff[s-1];
         qx_src[s]  = qx_ff[s-1];
         qy_src[s]  = qy_ff[s-1];
         den_src[s] = den_ff[s-1];
         fl_src[s]  = fl_ff[s-1];
      end
   end

   // resolve one quotient bit per stage, most significant first
   always_comb begin
      for (int s = 0; s < N; s++) begin
         trial[s] = cvp_pkg::REM_W'(den_src[s]) << (N - 1 - s);
         if (rx_src[s] >= trial[s]) begin
            rx_in[s] = rx_src[s] - trial[s];
            qx_in[s] = qx_src[s] | (N'(1) << (N - 1 - s));
         end else begin
            rx_in[s] = rx_src[s];
            qx_in[s] = qx_src[s];
         end
         if (ry_src[s] >= trial[s]) begin
            ry_in[s] = ry_src[s] - trial[s];
            qy_in[s] = qy_src[s] | (N'(1) << (N - 1 - s));
         end else begin
            ry_in[s] = ry_src[s];
            qy_in[s] = qy_src[s];
         end
      end
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         qx_ff  <= qx_in;
         qy_ff  <= qy_in;
         den_ff <= den_src;
         fl_ff  <= fl_src;
      end
   end

   assign out_valid      = valid_ff[N-1];
   assign out_data.quo_x = qx_ff[N-1];
   assign out_data.quo_y = qy_ff[N-1];
   assign out_data.flags = fl_ff[N-1];

endmodule

### src/camera_vertex_projection.sv
// Camera vertex projection: top level with registers, output stage and skid buffer.
//
// While the skid register is empty, accepts and projects one world vertex
// (Q16.16 x, y, z, w) per clock onto the screen through the camera set up by
// six registers, returning a re-centred, 16-bit saturated pixel position, a
// visibility flag and the mesh end mark. Stages: 4 transform, 3 operand, 18
// divider that each resolve one quotient bit, and the output register. A skid
// register behind the output register parks a result on an output stall,
// keeping req_ready high as the stall begins, and makes req_ready a plain
// register. Registers are written through the csr port, which is always
// ready; writes are meant for times when no vertex is in flight.
module camera_vertex_projection #(
   parameter int SCREEN_WIDTH  = cvp_pkg::SCREEN_WIDTH_DEF,
   parameter int SCREEN_HEIGHT = cvp_pkg::SCREEN_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  cvp_pkg::req_payload_type          req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output cvp_pkg::rsp_payload_type          rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cvp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cvp_pkg::AXIS_W-1:0]        csr_data
);

   `include "assert_macros.svh"

   localparam logic signed [cvp_pkg::OFS_W-1:0] HALF_W = cvp_pkg::OFS_W'(SCREEN_WIDTH / 2);
   localparam logic signed [cvp_pkg::OFS_W-1:0] HALF_H = cvp_pkg::OFS_W'(SCREEN_HEIGHT / 2);
   localparam logic [cvp_pkg::QUO_W:0]          MAG_CLAMP = {1'b1, {cvp_pkg::QUO_W{1'b0}}};
   localparam logic signed [cvp_pkg::OFS_W:0]   SAT_HI = 32767;
   localparam logic signed [cvp_pkg::OFS_W:0]   SAT_LO = -32768;

   cvp_pkg::csr_regs_type    regs_ff;
   logic                     pipe_adv;
   logic                     view_valid, op_valid, res_valid;
   cvp_pkg::view_type        view;
   cvp_pkg::div_op_type      op;
   cvp_pkg::div_res_type     res;

   logic [cvp_pkg::QUO_W:0]          mag_x, mag_y;
   logic signed [cvp_pkg::OFS_W-1:0] ofs_x, ofs_y;
   logic signed [cvp_pkg::OFS_W:0]   sum_x, sum_y;
   cvp_pkg::rsp_payload_type         rsp_in;
   cvp_pkg::rsp_payload_type         out_ff, skid_ff;
   logic                             out_valid_ff, skid_valid_ff;
   logic                             res_take;

   function automatic logic signed [cvp_pkg::SCR_W-1:0] sat16(
      input logic signed [cvp_pkg::OFS_W:0] v
   );
      logic signed [cvp_pkg::SCR_W-1:0] r;
      priority if (v > SAT_HI) begin
         r = 16'sh7FFF;
      end else if (v < SAT_LO) begin
         r = 16'sh8000;
      end else begin
         r = v[cvp_pkg::SCR_W-1:0];
      end
      return r;
   endfunction

   // write the camera registers
   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.cam_pos_x    <= '0;
         regs_ff.cam_pos_y    <= '0;
         regs_ff.cam_pos_z    <= '0;
         regs_ff.right_axis   <= cvp_pkg::AXIS_W'(48'h0000_0000_4000);
         regs_ff.up_axis      <= cvp_pkg::AXIS_W'(48'h0000_4000_0000);
         regs_ff.forward_axis <= cvp_pkg::AXIS_W'(48'h4000_0000_0000);
      end else if (csr_valid) begin
         unique case (csr_index)
            cvp_pkg::CSR_CAM_POS_X:    regs_ff.cam_pos_x    <= csr_data[cvp_pkg::COORD_W-1:0];
            cvp_pkg::CSR_CAM_POS_Y:    regs_ff.cam_pos_y    <= csr_data[cvp_pkg::COORD_W-1:0];
            cvp_pkg::CSR_CAM_POS_Z:    regs_ff.cam_pos_z    <= csr_data[cvp_pkg::COORD_W-1:0];
            cvp_pkg::CSR_RIGHT_AXIS:   regs_ff.right_axis   <= csr_data;
            cvp_pkg::CSR_UP_AXIS:      regs_ff.up_axis      <= csr_data;
            cvp_pkg::CSR_FORWARD_AXIS: regs_ff.forward_axis <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // hold the whole pipeline only while the skid register is occupied
   assign pipe_adv  = !skid_valid_ff;
   assign req_ready = pipe_adv;

   cvp_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .advance   (pipe_adv),
      .regs      (regs_ff),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (view_valid),
      .out_data  (view)
   );

   cvp_prep #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (pipe_adv),
      .in_valid  (view_valid),
      .in_data   (view),
      .out_valid (op_valid),
      .out_data  (op)
   );

   cvp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (pipe_adv),
      .in_valid  (op_valid),
      .in_data   (op),
      .out_valid (res_valid),
      .out_data  (res)
   );

   // apply sign and clamp, test the window, re-centre and saturate
   always_comb begin
      priority if (res.flags.zero_x) begin
         mag_x = '0;
      end else if (res.flags.ovf_x) begin
         mag_x = MAG_CLAMP;
      end else begin
         mag_x = {1'b0, res.quo_x};
      end
      priority if (res.flags.zero_y) begin
         mag_y = '0;
      end else if (res.flags.ovf_y) begin
         mag_y = MAG_CLAMP;
      end else begin
         mag_y = {1'b0, res.quo_y};
      end
      ofs_x = res.flags.neg_x ? -cvp_pkg::OFS_W'(mag_x) : cvp_pkg::OFS_W'(mag_x);
      ofs_y = res.flags.neg_y ? -cvp_pkg::OFS_W'(mag_y) : cvp_pkg::OFS_W'(mag_y);
      sum_x = (cvp_pkg::OFS_W+1)'(ofs_x) + (cvp_pkg::OFS_W+1)'(HALF_W);
      sum_y = (cvp_pkg::OFS_W+1)'(ofs_y) + (cvp_pkg::OFS_W+1)'(HALF_H);

      rsp_in.screen_x = sat16(sum_x);
      rsp_in.screen_y = sat16(sum_y);
      rsp_in.visible  = (ofs_x > -HALF_W) && (ofs_x < HALF_W)
                     && (ofs_y > -HALF_H) && (ofs_y < HALF_H) && res.flags.depth_ok;
      rsp_in.last_out = res.flags.last;
   end

   assign res_take = pipe_adv && res_valid;

   // output register with skid: refill from skid first, park a transaction on stall
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= res_take;
         end
      end else if (res_take) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || rsp_ready) begin
         out_ff <= skid_valid_ff ? skid_ff : rsp_in;
      end else if (res_take) begin
         skid_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   `ASSERT_NEVER(a_skid_without_out, clock, reset, skid_valid_ff && !out_valid_ff)
   `ASSERT_CLK(a_visible_x_on_screen, clock, reset, rsp_valid && rsp_data.visible |-> rsp_data.screen_x > 0 && rsp_data.screen_x < SCREEN_WIDTH)
   `ASSERT_CLK(a_visible_y_on_screen, clock, reset, rsp_valid && rsp_data.visible |-> rsp_data.screen_y > 0 && rsp_data.screen_y < SCREEN_HEIGHT)

endmodule

### tb/sv/tb_camera_vertex_projection.sv
// Self-checking testbench for the camera vertex projection block.
`timescale 1ns / 1ps

module tb_camera_vertex_projection;
   import cvp_pkg::*;

   localparam int HALF_W = SCREEN_WIDTH_DEF / 2;
   localparam int HALF_H = SCREEN_HEIGHT_DEF / 2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;
   localparam longint ONE_Q16 = 64'sd65536;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [AXIS_W-1:0] csr_data = '0;

   // camera copy kept by the predictor
   logic [COORD_W-1:0] cam_x, cam_y, cam_z;
   logic [AXIS_W-1:0] axis_right, axis_up, axis_fwd;

   rsp_payload_type pending_pixels[$];
   int err_count = 0;
   int cycle_count = 0;
   bit tx_idle = 0;
   bit rx_stall = 0;
   int idle_pct = 69;

   typedef struct {
      req_payload_type vtx;
      bit typed;
      rsp_payload_type pix;
   } vertex_row_type;

   camera_vertex_projection u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   // hold the watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_camera_vertex_projection failed");
         $finish;
      end
   end

   // stall the result channel according to the phase
   always @(posedge clock) begin
      rsp_ready <= rx_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
   end

   // check each result transaction against the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result transaction %h", rsp_data);
            err_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.screen_x !== want.screen_x) begin
               $error("screen_x expected %0d actual %0d", want.screen_x, rsp_data.screen_x);
               err_count++;
            end
            if (rsp_data.screen_y !== want.screen_y) begin
               $error("screen_y expected %0d actual %0d", want.screen_y, rsp_data.screen_y);
               err_count++;
            end
            if (rsp_data.visible !== want.visible) begin
               $error("visible expected %0b actual %0b", want.visible, rsp_data.visible);
               err_count++;
            end
            if (rsp_data.last_out !== want.last_out) begin
               $error("last_out expected %0b actual %0b", want.last_out, rsp_data.last_out);
               err_count++;
            end
         end
      end
   end

   function automatic longint floor_q16(longint prod, int sh);
      return prod >>> sh;
   endfunction

   function automatic longint axis_dot(longint dx, longint dy, longint dz,
                                       logic [AXIS_W-1:0] axis);
      longint ax, ay, az;
      ax = longint'($signed(axis[15:0]));
      ay = longint'($signed(axis[31:16]));
      az = longint'($signed(axis[47:32]));
      return floor_q16(dx * ax, COMP_FRAC) + floor_q16(dy * ay, COMP_FRAC)
           + floor_q16(dz * az, COMP_FRAC);
   endfunction

   // truncated k*num/(2*den), clamped to 2^24, zero depth saturates
   function automatic longint pixel_offset(longint num, longint den, longint k);
      longint unsigned an, ad, q0, r0, mag, ku;
      bit neg;
      if (num == 0) return 0;
      if (den == 0) return (num < 0) ? -(64'sd1 << 24) : (64'sd1 << 24);
      neg = (num < 0) != (den < 0);
      an = (num < 0) ? -num : num;
      ad = (den < 0) ? -den : den;
      ku = k;
      q0 = an / ad;
      r0 = an % ad;
      if (q0 >= (64'd1 << 20)) begin
         mag = 64'd1 << 24;
      end else begin
         mag = ((ku * q0) >> 1) + (((ku * q0) & 1) * ad + ku * r0) / (2 * ad);
         if (mag > (64'd1 << 24)) mag = 64'd1 << 24;
      end
      return neg ? -longint'(mag) : longint'(mag);
   endfunction

   function automatic logic [SCR_W-1:0] clamp16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[SCR_W-1:0];
   endfunction

   function automatic rsp_payload_type project_vertex(req_payload_type v);
      rsp_payload_type r;
      longint w, dx, dy, dz, vx, vy, vz, ox, oy;
      bit depth_ok;
      w  = longint'(v.vertex_w);
      dx = longint'(v.vertex_x) - floor_q16(w * longint'($signed(cam_x)), COORD_FRAC);
      dy = longint'(v.vertex_y) - floor_q16(w * longint'($signed(cam_y)), COORD_FRAC);
      dz = longint'(v.vertex_z) - floor_q16(w * longint'($signed(cam_z)), COORD_FRAC);
      vx = axis_dot(dx, dy, dz, axis_right);
      vy = axis_dot(dx, dy, dz, axis_up);
      vz = axis_dot(dx, dy, dz, axis_fwd);
      ox = pixel_offset(vx, vz, 3 * HALF_W);
      oy = pixel_offset(vy, -vz, 3 * HALF_H);
      if (w > 0) depth_ok = vz > w;
      else if (w < 0) depth_ok = vz < w;
      else depth_ok = vz > 0;
      r.screen_x = clamp16(ox + HALF_W);
      r.screen_y = clamp16(oy + HALF_H);
      r.visible  = ox > -HALF_W && ox < HALF_W && oy > -HALF_H && oy < HALF_H && depth_ok;
      r.last_out = v.last_in;
      return r;
   endfunction

   task automatic write_camera(logic [CSR_IDX_W-1:0] idx, logic [AXIS_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CAM_POS_X:    cam_x = value[COORD_W-1:0];
         CSR_CAM_POS_Y:    cam_y = value[COORD_W-1:0];
         CSR_CAM_POS_Z:    cam_z = value[COORD_W-1:0];
         CSR_RIGHT_AXIS:   axis_right = value;
         CSR_UP_AXIS:      axis_up = value;
         CSR_FORWARD_AXIS: axis_fwd = value;
         default: ;
      endcase
   endtask

   // send one vertex transaction; valid stays high into the next one when no gap
   task automatic send_vertex(req_payload_type v, bit typed, rsp_payload_type pix);
      if (tx_idle && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= v;
      do @(posedge clock); while (!req_ready);
      pending_pixels.push_back(typed ? pix : project_vertex(v));
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] rand_coord(int style);
      case (style)
         0: return $urandom();
         1: return $signed($urandom_range(2000)) - 1000 <<< 16;
         default: return $urandom() >>> $urandom_range(31);
      endcase
   endfunction

   function automatic logic [COMP_W-1:0] rand_comp();
      case ($urandom_range(3))
         0: return $urandom();
         1: return $urandom_range(1) ? 16'h4000 : 16'hC000;
         default: return $signed($urandom_range(32767)) - 16384;
      endcase
   endfunction

   function automatic req_payload_type rand_vertex();
      req_payload_type v;
      int style;
      style = $urandom_range(9);
      v.vertex_x = rand_coord(style < 2 ? 0 : (style < 7 ? 1 : 2));
      v.vertex_y = rand_coord(style < 2 ? 0 : (style < 7 ? 1 : 2));
      v.vertex_z = rand_coord(style < 2 ? 0 : (style < 7 ? 1 : 2));
      case ($urandom_range(9))
         0: v.vertex_w = $urandom();
         1: v.vertex_w = '0;
         2: v.vertex_w = -ONE_Q16;
         3: v.vertex_w = $urandom_range(4) <<< 16;
         default: v.vertex_w = ONE_Q16;
      endcase
      v.last_in = $urandom_range(1);
      return v;
   endfunction

   function automatic logic [AXIS_W-1:0] rand_axis(int setting);
      case (setting)
         1: return '1;
         2: return 48'h8000_8000_8000;
         3: return {$urandom(), $urandom()};
         default: return {rand_comp(), rand_comp(), rand_comp()};
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] rand_cam(int setting);
      case (setting)
         1: return 32'h7FFF_FFFF;
         2: return 32'h8000_0000;
         3: return $urandom();
         default: return $signed($urandom_range(200)) - 100 <<< 16;
      endcase
   endfunction

   vertex_row_type vertex_table[$];

   initial begin
      vertex_row_type row;
      int setting;
      cam_x = '0; cam_y = '0; cam_z = '0;
      axis_right = 48'h0000_0000_4000;
      axis_up    = 48'h0000_4000_0000;
      axis_fwd   = 48'h4000_0000_0000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed vertices with reset camera
      row = '{vtx: '{0, 0, 0, ONE_Q16, 1'b0}, typed: 1, pix: '{16'sd512, 16'sd384, 1'b0, 1'b0}};
      vertex_table.push_back(row);
      row = '{vtx: '{0, 0, 2 * ONE_Q16, ONE_Q16, 1'b1}, typed: 1,
              pix: '{16'sd512, 16'sd384, 1'b1, 1'b1}};
      vertex_table.push_back(row);
      row = '{vtx: '{ONE_Q16, 0, ONE_Q16, 0, 1'b0}, typed: 1,
              pix: '{16'sd1280, 16'sd384, 1'b0, 1'b0}};
      vertex_table.push_back(row);
      row = '{vtx: '{ONE_Q16, ONE_Q16, 0, ONE_Q16, 1'b0}, typed: 0, pix: '0};
      vertex_table.push_back(row);
      row = '{vtx: '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1},
              typed: 0, pix: '0};
      vertex_table.push_back(row);
      row = '{vtx: '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0},
              typed: 0, pix: '0};
      vertex_table.push_back(row);
      row = '{vtx: '{32'h8000_0000, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 1'b1}, typed: 0, pix: '0};
      vertex_table.push_back(row);
      row = '{vtx: '{100 * ONE_Q16, -50 * ONE_Q16, 4 * ONE_Q16, ONE_Q16, 1'b0},
              typed: 0, pix: '0};
      vertex_table.push_back(row);
      row = '{vtx: '{ONE_Q16, ONE_Q16, -3 * ONE_Q16, -ONE_Q16, 1'b0}, typed: 0, pix: '0};
      vertex_table.push_back(row);
      row = '{vtx: '{ONE_Q16, 2, ONE_Q16 * 3, ONE_Q16 * 3, 1'b1}, typed: 0, pix: '0};
      vertex_table.push_back(row);
      row = '{vtx: '{1, -1, 1, 0, 1'b0}, typed: 0, pix: '0};
      vertex_table.push_back(row);
      row = '{vtx: '{0, 5 * ONE_Q16, -2 * ONE_Q16, 0, 1'b1}, typed: 0, pix: '0};
      vertex_table.push_back(row);
      foreach (vertex_table[i]) send_vertex(vertex_table[i].vtx, vertex_table[i].typed,
                                            vertex_table[i].pix);
      drain_pipe();

      // random phases: new camera, then a burst of vertices
      for (int phase = 0; phase < 8; phase++) begin
         tx_idle  = (phase % 4 == 1) || (phase % 4 == 3);
         rx_stall = (phase % 4 == 2) || (phase % 4 == 3);
         // idle share is 36 percent with both sides throttled, 69 with one side alone
         idle_pct = (phase % 4 == 3) ? 36 : 69;
         setting = (phase < 3) ? phase + 1 : $urandom_range(4) == 0 ? 3 : 0;
         if (phase == 7) setting = 0;
         write_camera(CSR_CAM_POS_X, rand_cam(setting));
         write_camera(CSR_CAM_POS_Y, rand_cam(phase == 0 ? 2 : setting));
         write_camera(CSR_CAM_POS_Z, rand_cam(setting == 1 ? 0 : setting));
         write_camera(CSR_RIGHT_AXIS, rand_axis(setting));
         write_camera(CSR_UP_AXIS, rand_axis(phase == 1 ? 3 : setting));
         write_camera(CSR_FORWARD_AXIS, rand_axis(phase == 2 ? 3 : setting));
         write_camera(CSR_UNUSED_IDX, {$urandom(), $urandom()});
         repeat (185) send_vertex(rand_vertex(), 0, '0);
         drain_pipe();
      end

      if (err_count == 0) begin
         $display("tb_camera_vertex_projection passed");
      end else begin
         $display("tb_camera_vertex_projection failed");
      end
      $finish;
   end

endmodule

### files.f
+incdir+src
src/cvp_pkg.sv
src/cvp_xform.sv
src/cvp_prep.sv
src/cvp_div.sv
src/camera_vertex_projection.sv
tb/sv/tb_camera_vertex_projection.sv
